>>> hw/rtl/depth_max_pool_downscaler_core_macros.svh
// Assertion macros shared by the depth max-pool downscaler RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DEPTH_MAX_POOL_DOWNSCALER_CORE_MACROS_SVH
`define DEPTH_MAX_POOL_DOWNSCALER_CORE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define DMPD_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("dmpd check failed");

// Same-cycle implication outside reset.
`define DMPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dmpd check failed");

`endif

>>> hw/rtl/dmpd_pkg.sv
// Package for the depth max-pool downscaler: register map, config types,
// pipeline control struct and the size clamp function. No dependencies.
package dmpd_pkg;

    localparam int IN_W_BITS         = 13;
    localparam int IN_H_BITS         = 13;
    localparam int OUT_W_BITS        = 12;
    localparam int OUT_H_BITS        = 13;
    localparam int ROW_BITS          = 12;
    localparam int ACC_BITS          = 26;
    localparam int ADDR_BITS         = 5;
    localparam int DATA_BITS         = 32;
    localparam int MAX_IN_HEIGHT     = 4096;
    localparam int DEF_MAX_IN_WIDTH  = 4096;
    localparam int DEF_MAX_OUT_WIDTH = 2048;
    localparam int DEF_SAMPLE_BITS   = 10;

    typedef enum logic [2:0] {
        REG_SCALE_EN   = 3'd0,
        REG_IN_WIDTH   = 3'd1,
        REG_IN_HEIGHT  = 3'd2,
        REG_OUT_WIDTH  = 3'd3,
        REG_OUT_HEIGHT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic                  scale_en;
        logic [IN_W_BITS-1:0]  in_width;
        logic [IN_H_BITS-1:0]  in_height;
        logic [OUT_W_BITS-1:0] out_width;
        logic [OUT_H_BITS-1:0] out_height;
    } t_cfg;

    // clamped frame sizes
    typedef struct packed {
        logic [IN_W_BITS-1:0]  w_in;
        logic [IN_H_BITS-1:0]  h_in;
        logic [OUT_W_BITS-1:0] w_out;
        logic [OUT_H_BITS-1:0] h_out;
    } t_eff;

    // per-item control handed from the counter stage to the pooling stage
    typedef struct packed {
        logic emit;
        logic wr;
        logic use_mem;
        logic re;
        logic fe;
    } t_s1_ctl;

    localparam t_cfg CFG_RST = '{
        scale_en:   1'b0,
        in_width:   13'd4096,
        in_height:  13'd4096,
        out_width:  12'd2048,
        out_height: 13'd2048
    };

    function automatic t_eff eff_of(t_cfg c, int max_in_w, int max_out_w);
        t_eff e;
        int   lim;
        if (c.in_width == '0) begin
            e.w_in = IN_W_BITS'(1);
        end else if (int'(c.in_width) > max_in_w) begin
            e.w_in = IN_W_BITS'(max_in_w);
        end else begin
            e.w_in = c.in_width;
        end
        if (c.in_height == '0) begin
            e.h_in = IN_H_BITS'(1);
        end else if (int'(c.in_height) > MAX_IN_HEIGHT) begin
            e.h_in = IN_H_BITS'(MAX_IN_HEIGHT);
        end else begin
            e.h_in = c.in_height;
        end
        lim = (int'(e.w_in) < max_out_w) ? int'(e.w_in) : max_out_w;
        if (c.out_width == '0) begin
            e.w_out = OUT_W_BITS'(1);
        end else if (int'(c.out_width) > lim) begin
            e.w_out = OUT_W_BITS'(lim);
        end else begin
            e.w_out = c.out_width;
        end
        if (c.out_height == '0) begin
            e.h_out = OUT_H_BITS'(1);
        end else if (c.out_height > e.h_in) begin
            e.h_out = e.h_in;
        end else begin
            e.h_out = c.out_height;
        end
        return e;
    endfunction

endpackage

>>> hw/rtl/depth_max_pool_downscaler_core.sv
// A result passes dmpd_pool's stage-1 and output registers to the master side.
// Throughput: one sample per cycle while the master side takes results; set by
// the window counter update and the single line store read/write per cycle.
// Reset (i_rst_n, synchronous): registers return to defaults, frame restarts,
// line store keeps its contents and needs no clearing pass.
// Depends on dmpd_pkg, dmpd_cfg, dmpd_ctrl, dmpd_pool.
module depth_max_pool_downscaler_core #(
    parameter int MAX_IN_WIDTH  = dmpd_pkg::DEF_MAX_IN_WIDTH,
    parameter int MAX_OUT_WIDTH = dmpd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int SAMPLE_BITS   = dmpd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dmpd_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [dmpd_pkg::DATA_BITS-1:0]       pwdata,
    output logic [dmpd_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,  // depth_in
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     o_m_tdata,  // depth_out
    output logic                                 o_m_tlast,  // row_end
    output logic                                 o_m_tuser   // frame_end
);
    import dmpd_pkg::*;

    localparam int IdxW = $clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2);
    localparam int TdW  = ((SAMPLE_BITS + 7) / 8) * 8;

    logic                   scale_en;
    logic                   restart;
    t_eff                   eff;
    t_eff                   eff_nxt;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] s0_max;
    logic [IdxW-1:0]        s0_idx;
    t_s1_ctl                s0_ctl;
    logic [SAMPLE_BITS-1:0] depth;

    assign accept = i_s_tvalid && o_s_tready;

    dmpd_cfg #(
        .MAX_IN_WIDTH  (MAX_IN_WIDTH),
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_scale_en (scale_en),
        .o_eff      (eff),
        .o_eff_nxt  (eff_nxt),
        .o_restart  (restart)
    );

    dmpd_ctrl #(
        .MAX_IN_WIDTH  (MAX_IN_WIDTH),
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_sample   (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_scale_en (scale_en),
        .i_restart  (restart),
        .i_eff      (eff),
        .i_eff_nxt  (eff_nxt),
        .o_max      (s0_max),
        .o_idx      (s0_idx),
        .o_ctl      (s0_ctl)
    );

    dmpd_pool #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_max       (s0_max),
        .i_idx       (s0_idx),
        .i_ctl       (s0_ctl),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_depth     (depth),
        .o_row_end   (o_m_tlast),
        .o_frame_end (o_m_tuser)
    );

    assign o_m_tdata = TdW'(depth);

endmodule

>>> hw/rtl/dmpd_cfg.sv
// APB-style register file of the depth max-pool downscaler.
// Depends on dmpd_pkg; gives clamped sizes and a frame restart on writes.
module dmpd_cfg #(
    parameter int MAX_IN_WIDTH  = dmpd_pkg::DEF_MAX_IN_WIDTH,
    parameter int MAX_OUT_WIDTH = dmpd_pkg::DEF_MAX_OUT_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dmpd_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [dmpd_pkg::DATA_BITS-1:0]   pwdata,
    output logic [dmpd_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready,
    output logic                             o_scale_en,
    output dmpd_pkg::t_eff                   o_eff,
    output dmpd_pkg::t_eff                   o_eff_nxt,
    output logic                             o_restart
);
    import dmpd_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr;
    logic     hit;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_BITS-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        hit   = 1'b1;
        unique case (idx)
            REG_SCALE_EN:   n_cfg.scale_en   = pwdata[0];
            REG_IN_WIDTH:   n_cfg.in_width   = pwdata[IN_W_BITS-1:0];
            REG_IN_HEIGHT:  n_cfg.in_height  = pwdata[IN_H_BITS-1:0];
            REG_OUT_WIDTH:  n_cfg.out_width  = pwdata[OUT_W_BITS-1:0];
            REG_OUT_HEIGHT: n_cfg.out_height = pwdata[OUT_H_BITS-1:0];
            default:        hit              = 1'b0;
        endcase
    end

    always_comb begin
        unique case (idx)
            REG_SCALE_EN:   prdata = DATA_BITS'(r_cfg.scale_en);
            REG_IN_WIDTH:   prdata = DATA_BITS'(r_cfg.in_width);
            REG_IN_HEIGHT:  prdata = DATA_BITS'(r_cfg.in_height);
            REG_OUT_WIDTH:  prdata = DATA_BITS'(r_cfg.out_width);
            REG_OUT_HEIGHT: prdata = DATA_BITS'(r_cfg.out_height);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else if (wr && hit) begin
            r_cfg <= n_cfg;
        end
    end

    assign o_restart  = wr && hit;
    assign o_scale_en = r_cfg.scale_en;
    assign o_eff      = eff_of(r_cfg, MAX_IN_WIDTH, MAX_OUT_WIDTH);
    assign o_eff_nxt  = eff_of(n_cfg, MAX_IN_WIDTH, MAX_OUT_WIDTH);

endmodule

>>> hw/rtl/dmpd_ctrl.sv
// Window tracking stage: position counters, bound accumulators, running max.
// Depends on dmpd_pkg and the assertion macro header.
`include "depth_max_pool_downscaler_core_macros.svh"
module dmpd_ctrl #(
    parameter int MAX_IN_WIDTH  = dmpd_pkg::DEF_MAX_IN_WIDTH,
    parameter int MAX_OUT_WIDTH = dmpd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int SAMPLE_BITS   = dmpd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [SAMPLE_BITS-1:0]      i_sample,
    input  logic                        i_scale_en,
    input  logic                        i_restart,
    input  dmpd_pkg::t_eff              i_eff,
    input  dmpd_pkg::t_eff              i_eff_nxt,
    output logic [SAMPLE_BITS-1:0]      o_max,
    output logic [$clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2)-1:0] o_idx,
    output dmpd_pkg::t_s1_ctl           o_ctl
);
    import dmpd_pkg::*;

    localparam int IdxW = $clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2);
    localparam int IcW  = $clog2(MAX_IN_WIDTH);
    localparam t_eff EffRst = eff_of(CFG_RST, MAX_IN_WIDTH, MAX_OUT_WIDTH);

    logic [IcW-1:0]         r_in_col,   n_in_col;
    logic [ROW_BITS-1:0]    r_in_row,   n_in_row;
    logic [IdxW-1:0]        r_out_col,  n_out_col;
    logic [ROW_BITS-1:0]    r_out_row,  n_out_row;
    logic [ACC_BITS-1:0]    r_col_pos,  n_col_pos;
    logic [ACC_BITS-1:0]    r_col_bnd,  n_col_bnd;
    logic [ACC_BITS-1:0]    r_row_pos,  n_row_pos;
    logic [ACC_BITS-1:0]    r_row_bnd,  n_row_bnd;
    logic [ACC_BITS-1:0]    r_row_base, n_row_base;
    logic [SAMPLE_BITS-1:0] r_cur_max,  n_cur_max;

    logic                   col_last, row_last, row_first;
    logic                   col_end, row_end_in, out_col_end, out_row_end;
    logic                   do_restart;
    logic [SAMPLE_BITS-1:0] m;
    t_eff                   eff_src;

    assign col_last    = r_col_pos > r_col_bnd;
    assign row_last    = r_row_pos > r_row_bnd;
    assign row_first   = (r_row_base + ACC_BITS'(i_eff.h_in)) <= r_row_bnd;
    assign col_end     = (32'(r_in_col) + 32'd1) >= 32'(i_eff.w_in);
    assign row_end_in  = (32'(r_in_row) + 32'd1) >= 32'(i_eff.h_in);
    assign out_col_end = (32'(r_out_col) + 32'd1) >= 32'(i_eff.w_out);
    assign out_row_end = (32'(r_out_row) + 32'd1) >= 32'(i_eff.h_out);
    assign m           = (i_sample > r_cur_max) ? i_sample : r_cur_max;
    assign o_idx       = r_out_col;

    always_comb begin
        if (!i_scale_en) begin
            o_max         = i_sample;
            o_ctl.emit    = 1'b1;
            o_ctl.wr      = 1'b0;
            o_ctl.use_mem = 1'b0;
            o_ctl.re      = col_end;
            o_ctl.fe      = col_end && row_end_in;
        end else begin
            o_max         = m;
            o_ctl.emit    = col_last && row_last;
            o_ctl.wr      = col_last && !row_last;
            o_ctl.use_mem = !row_first;
            o_ctl.re      = out_col_end;
            o_ctl.fe      = out_col_end && out_row_end;
        end
    end

    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_col_pos  = r_col_pos;
        n_col_bnd  = r_col_bnd;
        n_row_pos  = r_row_pos;
        n_row_bnd  = r_row_bnd;
        n_row_base = r_row_base;
        n_cur_max  = r_cur_max;
        do_restart = i_restart;
        eff_src    = i_restart ? i_eff_nxt : i_eff;

        if (i_accept && !i_scale_en) begin
            if (col_end) begin
                n_in_col = '0;
                n_in_row = row_end_in ? '0 : r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
        end else if (i_accept) begin
            if (col_last) begin
                n_cur_max = '0;
                n_out_col = r_out_col + 1'b1;
                n_col_bnd = r_col_bnd + ACC_BITS'(i_eff.w_in);
            end else begin
                n_cur_max = m;
            end
            n_in_col  = r_in_col + 1'b1;
            n_col_pos = r_col_pos + ACC_BITS'(i_eff.w_out);
            if (col_end) begin
                n_in_col  = '0;
                n_out_col = '0;
                n_col_bnd = ACC_BITS'(i_eff.w_in);
                n_col_pos = ACC_BITS'(i_eff.w_out) << 1;
                n_cur_max = '0;
                if (row_last) begin
                    n_out_row = r_out_row + 1'b1;
                    n_row_bnd = r_row_bnd + ACC_BITS'(i_eff.h_in);
                end
                n_in_row   = r_in_row + 1'b1;
                n_row_pos  = r_row_pos + ACC_BITS'(i_eff.h_out);
                n_row_base = r_row_base + ACC_BITS'(i_eff.h_out);
                if (row_end_in) begin
                    do_restart = 1'b1;
                end
            end
        end

        if (do_restart) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_col_bnd  = ACC_BITS'(eff_src.w_in);
            n_col_pos  = ACC_BITS'(eff_src.w_out) << 1;
            n_row_bnd  = ACC_BITS'(eff_src.h_in);
            n_row_pos  = ACC_BITS'(eff_src.h_out) << 1;
            n_row_base = '0;
            n_cur_max  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_col_bnd  <= ACC_BITS'(EffRst.w_in);
            r_col_pos  <= ACC_BITS'(EffRst.w_out) << 1;
            r_row_bnd  <= ACC_BITS'(EffRst.h_in);
            r_row_pos  <= ACC_BITS'(EffRst.h_out) << 1;
            r_row_base <= '0;
            r_cur_max  <= '0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_col_bnd  <= n_col_bnd;
            r_col_pos  <= n_col_pos;
            r_row_bnd  <= n_row_bnd;
            r_row_pos  <= n_row_pos;
            r_row_base <= n_row_base;
            r_cur_max  <= n_cur_max;
        end
    end

    `DMPD_ASSERT_ALWAYS(a_in_col_range, i_clk, i_rst_n, 32'(r_in_col) < 32'(i_eff.w_in))
    `DMPD_ASSERT_ALWAYS(a_in_row_range, i_clk, i_rst_n, 32'(r_in_row) < 32'(i_eff.h_in))
    `DMPD_ASSERT_ALWAYS(a_out_col_range, i_clk, i_rst_n, 32'(r_out_col) < 32'(i_eff.w_out))

endmodule

>>> hw/rtl/dmpd_pool.sv
// Pooling stage: band line store with write forwarding, result register.
// Depends on dmpd_pkg and the assertion macro header.
`include "depth_max_pool_downscaler_core_macros.svh"
module dmpd_pool #(
    parameter int MAX_OUT_WIDTH = dmpd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int SAMPLE_BITS   = dmpd_pkg::DEF_SAMPLE_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [SAMPLE_BITS-1:0]      i_max,
    input  logic [$clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2)-1:0] i_idx,
    input  dmpd_pkg::t_s1_ctl           i_ctl,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [SAMPLE_BITS-1:0]      o_depth,
    output logic                        o_row_end,
    output logic                        o_frame_end
);
    import dmpd_pkg::*;

    localparam int IdxW = $clog2(MAX_OUT_WIDTH > 1 ? MAX_OUT_WIDTH : 2);

    logic [SAMPLE_BITS-1:0] r_band_max [MAX_OUT_WIDTH];
    logic [SAMPLE_BITS-1:0] r_rd;

    logic                   r_s1_valid;
    t_s1_ctl                r_s1_ctl;
    logic [SAMPLE_BITS-1:0] r_s1_max;
    logic [IdxW-1:0]        r_s1_idx;

    logic                   r_fwd_valid;
    logic [IdxW-1:0]        r_fwd_idx;
    logic [SAMPLE_BITS-1:0] r_fwd_data;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_depth;
    logic                   r_out_re;
    logic                   r_out_fe;

    logic                   out_free;
    logic                   s1_go;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] prev;
    logic [SAMPLE_BITS-1:0] t;

    assign out_free   = !r_out_valid || i_ready;
    assign s1_go      = r_s1_valid && (!r_s1_ctl.emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_go;
    assign accept     = i_in_valid && o_in_ready;

    // last retired write covers the read issued on the same edge
    assign prev = (r_fwd_valid && (r_fwd_idx == r_s1_idx)) ? r_fwd_data : r_rd;
    assign t    = (r_s1_ctl.use_mem && (prev > r_s1_max)) ? prev : r_s1_max;

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_ctl.wr) begin
            r_band_max[r_s1_idx] <= t;
        end
        if (accept) begin
            r_rd <= r_band_max[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go && r_s1_ctl.wr) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_go && r_s1_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= i_ctl;
            r_s1_max <= i_max;
            r_s1_idx <= i_idx;
        end
        if (s1_go && r_s1_ctl.wr) begin
            r_fwd_idx  <= r_s1_idx;
            r_fwd_data <= t;
        end
        if (s1_go && r_s1_ctl.emit) begin
            r_out_depth <= t;
            r_out_re    <= r_s1_ctl.re;
            r_out_fe    <= r_s1_ctl.fe;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_depth     = r_out_depth;
    assign o_row_end   = r_out_re;
    assign o_frame_end = r_out_fe;

    `DMPD_ASSERT_IMPLY(a_wr_xor_emit, i_clk, i_rst_n, r_s1_valid, !(r_s1_ctl.wr && r_s1_ctl.emit))
    `DMPD_ASSERT_IMPLY(a_fe_has_re, i_clk, i_rst_n, r_out_valid && r_out_fe, r_out_re)

endmodule

>>> bench/depth_max_pool_downscaler_core_tb.sv
// Testbench for depth_max_pool_downscaler_core: drives depth samples under random idling,
// predicts the pooled pixels in a scoreboard class and checks every output transfer.
// Depends on dmpd_pkg and the RTL of the core.
`timescale 1ns / 100ps

module depth_max_pool_downscaler_core_tb;
    import dmpd_pkg::*;

    typedef struct packed {
        logic [9:0] depth;
        logic       row_end;
        logic       frame_end;
    } t_pixel;

    class t_depth_pool_scoreboard;
        bit          scale_en;
        bit [12:0]   cfg_in_w;
        bit [12:0]   cfg_in_h;
        bit [11:0]   cfg_out_w;
        bit [12:0]   cfg_out_h;
        bit [9:0]    band_max [DEF_MAX_OUT_WIDTH];
        int unsigned in_col, in_row, out_col, out_row, col_acc, row_acc;
        bit [9:0]    cur_max;
        t_pixel      pending_px [$];
        int          mismatches;

        function new();
            scale_en   = 1'b0;
            cfg_in_w   = 13'd4096;
            cfg_in_h   = 13'd4096;
            cfg_out_w  = 12'd2048;
            cfg_out_h  = 13'd2048;
            mismatches = 0;
            restart_frame();
        endfunction

        function int unsigned eff_in_w();
            if (cfg_in_w == 0) return 1;
            return (cfg_in_w > DEF_MAX_IN_WIDTH) ? DEF_MAX_IN_WIDTH : cfg_in_w;
        endfunction

        function int unsigned eff_in_h();
            if (cfg_in_h == 0) return 1;
            return (cfg_in_h > MAX_IN_HEIGHT) ? MAX_IN_HEIGHT : cfg_in_h;
        endfunction

        function int unsigned eff_out_w();
            int unsigned lim;
            lim = (eff_in_w() < DEF_MAX_OUT_WIDTH) ? eff_in_w() : DEF_MAX_OUT_WIDTH;
            if (cfg_out_w == 0) return 1;
            return (cfg_out_w > lim) ? lim : cfg_out_w;
        endfunction

        function int unsigned eff_out_h();
            if (cfg_out_h == 0) return 1;
            return (cfg_out_h > eff_in_h()) ? eff_in_h() : cfg_out_h;
        endfunction

        function void restart_frame();
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            col_acc = eff_in_w();
            row_acc = eff_in_h();
            cur_max = '0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_SCALE_EN:   scale_en  = val[0];
                REG_IN_WIDTH:   cfg_in_w  = val[12:0];
                REG_IN_HEIGHT:  cfg_in_h  = val[12:0];
                REG_OUT_WIDTH:  cfg_out_w = val[11:0];
                REG_OUT_HEIGHT: cfg_out_h = val[12:0];
                default: return;
            endcase
            restart_frame();
        endfunction

        // advance the pooling state by one input sample
        function void note_sample(logic [9:0] v);
            t_pixel      px;
            int unsigned in_w, in_h, o_w, o_h, idx;
            bit          col_last, row_last, row_first;
            bit [9:0]    m, t;
            in_w = eff_in_w();
            in_h = eff_in_h();
            o_w  = eff_out_w();
            o_h  = eff_out_h();
            if (!scale_en) begin
                px.depth     = v;
                px.row_end   = (in_col + 1 >= in_w);
                px.frame_end = px.row_end && (in_row + 1 >= in_h);
                if (px.row_end) begin
                    in_col = 0;
                    in_row = px.frame_end ? 0 : in_row + 1;
                end else begin
                    in_col++;
                end
                pending_px.push_back(px);
                return;
            end
            col_last  = (in_col + 2) * o_w > col_acc;
            row_last  = (in_row + 2) * o_h > row_acc;
            row_first = in_row * o_h + in_h <= row_acc;
            m   = (v > cur_max) ? v : cur_max;
            idx = (out_col >= DEF_MAX_OUT_WIDTH) ? DEF_MAX_OUT_WIDTH - 1 : out_col;
            if (col_last) begin
                t = m;
                if (!row_first && band_max[idx] > t) t = band_max[idx];
                if (row_last) begin
                    px.depth     = t;
                    px.row_end   = (out_col + 1 >= o_w);
                    px.frame_end = px.row_end && (out_row + 1 >= o_h);
                    pending_px.push_back(px);
                end else begin
                    band_max[idx] = t;
                end
                cur_max = '0;
                out_col++;
                col_acc += in_w;
            end else begin
                cur_max = m;
            end
            in_col++;
            if (in_col >= in_w) begin
                in_col  = 0;
                out_col = 0;
                col_acc = in_w;
                cur_max = '0;
                if (row_last) begin
                    out_row++;
                    row_acc += in_h;
                end
                in_row++;
                if (in_row >= in_h) restart_frame();
            end
        endfunction

        function void check_pixel(logic [9:0] d, logic re, logic fe);
            t_pixel exp_px;
            if (pending_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel depth=%0d last=%b user=%b",
                             $time, d, re, fe);
                return;
            end
            exp_px = pending_px.pop_front();
            if (exp_px.depth !== d || exp_px.row_end !== re || exp_px.frame_end !== fe) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pixel mismatch exp depth=%0d last=%b user=%b, got %0d %b %b",
                             $time, exp_px.depth, exp_px.row_end, exp_px.frame_end, d, re, fe);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [DATA_BITS-1:0] pwdata = '0;
    logic [DATA_BITS-1:0] prdata;
    logic        pready;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;

    int tx_gap_max = 7;
    int rx_gap_max = 7;
    int rx_hold = 0;
    t_depth_pool_scoreboard sb;

    depth_max_pool_downscaler_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [9:0] depth_in
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [9:0] depth_out
        .o_m_tlast  (o_m_tlast),   // row_end
        .o_m_tuser  (o_m_tuser)    // frame_end
    );

    always #10 i_clk = ~i_clk;

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_sample(input logic [9:0] v);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {6'b0, v};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(v);
    endtask

    // wait out all expected pixels plus the pipeline depth
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (sb.pending_px.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_config(input bit scale, input logic [12:0] in_w, input logic [12:0] in_h,
                              input logic [11:0] out_w, input logic [12:0] out_h);
        drain();
        apb_write(REG_SCALE_EN, {31'b0, scale});
        apb_write(REG_IN_WIDTH, {19'b0, in_w});
        apb_write(REG_IN_HEIGHT, {19'b0, in_h});
        apb_write(REG_OUT_WIDTH, {20'b0, out_w});
        apb_write(REG_OUT_HEIGHT, {19'b0, out_h});
    endtask

    task automatic run_samples(input int n);
        logic [9:0] v;
        repeat (n) begin
            case ($urandom_range(0, 7))
                0:       v = 10'd0;
                1:       v = 10'd1023;
                default: v = 10'($urandom_range(0, 1023));
            endcase
            send_sample(v);
        end
    endtask

    task automatic random_phase(output int n);
        bit          scale;
        logic [12:0] in_w, in_h, out_h;
        logic [11:0] out_w;
        int          area;
        scale = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 7) == 0) begin
            in_w  = 13'($urandom);
            in_h  = 13'($urandom);
            out_w = 12'($urandom);
            out_h = 13'($urandom);
        end else begin
            in_w  = 13'($urandom_range(0, 12));
            in_h  = 13'($urandom_range(0, 9));
            out_w = 12'($urandom_range(0, 32'(in_w) + 2));
            out_h = 13'($urandom_range(0, 32'(in_h) + 2));
        end
        set_config(scale, in_w, in_h, out_w, out_h);
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        area = sb.eff_in_w() * sb.eff_in_h();
        n = (area <= 40) ? $urandom_range(1, 3 * area) : $urandom_range(1, 120);
        run_samples(n);
    endtask

    // receiver: random stalls, one long hold on request
    initial begin
        int gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            if (gap > 0) begin
                i_m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_pixel(o_m_tdata[9:0], o_m_tlast, o_m_tuser);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [9:0] pool_seq [8];
        int         rand_items;
        int         n;
        pool_seq   = '{10'd1023, 10'd0, 10'd5, 10'd7, 10'd0, 10'd1023, 10'd3, 10'd2};
        rand_items = 0;
        sb = new();
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state passes samples through
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'h155);
        send_sample(10'h2AA);

        // 2x2 windows over a 4x2 frame
        set_config(1'b1, 13'd4, 13'd2, 12'd2, 13'd1);
        foreach (pool_seq[k]) send_sample(pool_seq[k]);

        // output larger than input: clamped to identity
        set_config(1'b1, 13'd2, 13'd2, 12'd7, 13'd9);
        run_samples(4);

        // pass through with row and frame marks
        set_config(1'b0, 13'd3, 13'd2, 12'd1, 13'd1);
        run_samples(6);

        // widest frame, sizes clamped from above and below
        set_config(1'b1, 13'h1FFF, 13'd1, 12'hFFF, 13'd0);
        run_samples(160);

        // one-column frame: back-to-back transfers rewrite entry zero until each window emits
        set_config(1'b1, 13'd1, 13'd6, 12'd1, 13'd2);
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_samples(12);
        rx_gap_max = 7;

        // long receiver hold against a full-rate sender
        set_config(1'b0, 13'd5, 13'd4, 12'd5, 13'd4);
        tx_gap_max = 0;
        rx_hold    = 300;
        run_samples(60);

        while (rand_items < 560) begin
            random_phase(n);
            rand_items += n;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_px.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
